@@ hw/rtl/mgrc_pkg.sv @@
// Shared types and constants for the mono glyph row compositor.
// Holds item structs, configuration struct and register index codes.
// No dependencies.
package mgrc_pkg;

   // Default buffer depth in bytes.
   localparam int MGRC_MAX_ROW_BYTES = 64;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHAR_SPACE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES  = 2'd2;

   localparam logic [6:0] ROW_BYTES_RESET = 7'd4;

   // Item operation codes.
   localparam logic OP_GLYPH   = 1'b0;
   localparam logic OP_END_ROW = 1'b1;

   typedef struct packed {
      logic       operation;
      logic [7:0] glyph_byte;
      logic [7:0] glyph_width;
      logic       byte_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0] char_space;
      logic              invert;
      logic [6:0]        row_bytes;
   } cfg_type;

endpackage

@@ hw/rtl/mgrc_line_mem.sv @@
// Line buffer memory: one write port, one registered read port.
// Per-entry valid bits make a cleared entry read as zero.
// Depends on mgrc_pkg.
module mgrc_line_mem
   import mgrc_pkg::*;
#(
   parameter int MAX_ROW_BYTES = MGRC_MAX_ROW_BYTES,
   localparam int AW = $clog2(MAX_ROW_BYTES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          clear,
   output logic [7:0]    rd_data
);

   logic [7:0]               mem [MAX_ROW_BYTES];
   logic [MAX_ROW_BYTES-1:0] valid_ff;
   logic [7:0]               rd_data_ff;
   logic                     rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'h00;

endmodule

@@ hw/rtl/mgrc_ctrl.sv @@
// Sequencer for the compositor: read-modify-write of glyph bytes,
// pen tracking and row emission through the result register.
// Depends on mgrc_pkg; drives mgrc_line_mem.
module mgrc_ctrl
   import mgrc_pkg::*;
#(
   parameter int MAX_ROW_BYTES = MGRC_MAX_ROW_BYTES,
   localparam int AW = $clog2(MAX_ROW_BYTES),
   localparam int CW = $clog2(MAX_ROW_BYTES + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   output logic          rd_en,
   output logic [AW-1:0] rd_addr,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output logic          clear,
   input  logic [7:0]    rd_data
);

   typedef enum logic [2:0] {
      IDLE,
      GLYPH_WR,
      CARRY_WR,
      EMIT_RD,
      EMIT_LD,
      CLEAR_ROW
   } state_type;

   state_type   state_ff, state_in;
   logic [15:0] pen_ff, pen_in;
   logic [7:0]  span_ff, span_in;
   logic [7:0]  carry_ff, carry_in;
   req_type     req_ff, req_in;
   logic [13:0] idx_ff, idx_in;
   logic [CW-1:0] k_ff, k_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [13:0] idx_new;
   logic [14:0] idx1;
   logic [2:0]  bias;
   logic [7:0]  val;
   logic [15:0] shl;
   logic [8:0]  neg_mag;
   logic        cancel;
   logic [15:0] pen_adv;
   logic [CW-1:0] row_n;
   logic        slot_free;
   logic        k_last;

   always_comb begin
      idx_new = {1'b0, pen_ff[15:3]} + 14'(span_ff);
      idx1    = 15'(idx_ff) + 15'd1;
      bias    = pen_ff[2:0];
      val     = (req_ff.glyph_byte >> bias) | carry_ff;
      shl     = {req_ff.glyph_byte, 8'h00} >> bias;
      // Negative spacing at least as wide as the glyph cancels the advance.
      neg_mag = 9'd0 - {cfg.char_space[7], cfg.char_space};
      cancel  = cfg.char_space[7] && (neg_mag >= {1'b0, req_ff.glyph_width});
      pen_adv = pen_ff + 16'(req_ff.glyph_width)
                + {{8{cfg.char_space[7]}}, cfg.char_space};
      row_n   = (32'(cfg.row_bytes) > MAX_ROW_BYTES) ? CW'(MAX_ROW_BYTES)
                                                      : CW'(cfg.row_bytes);
      k_last    = (k_ff + CW'(1)) == row_n;
      slot_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      pen_in       = pen_ff;
      span_in      = span_ff;
      carry_in     = carry_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_new[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data | val;
      clear        = 1'b0;

      unique case (state_ff)
         IDLE: begin
            rd_en = 1'b1;
            if (req_valid) begin
               req_in = req_data;
               idx_in = idx_new;
               k_in   = '0;
               if (req_data.operation == OP_GLYPH) begin
                  state_in = GLYPH_WR;
               end else if (row_n == '0) begin
                  state_in = CLEAR_ROW;
               end else begin
                  state_in = EMIT_RD;
               end
            end
         end
         GLYPH_WR: begin
            wr_en    = 32'(idx_ff) < MAX_ROW_BYTES;
            carry_in = shl[7:0];
            if (req_ff.byte_last) begin
               span_in  = 8'd0;
               pen_in   = cancel ? pen_ff : pen_adv;
               rd_en    = 1'b1;
               rd_addr  = idx1[AW-1:0];
               state_in = CARRY_WR;
            end else begin
               if (span_ff != 8'hFF) begin
                  span_in = span_ff + 8'd1;
               end
               state_in = IDLE;
            end
         end
         CARRY_WR: begin
            wr_en    = 32'(idx1) < MAX_ROW_BYTES;
            wr_addr  = idx1[AW-1:0];
            wr_data  = rd_data | carry_ff;
            carry_in = 8'd0;
            state_in = IDLE;
         end
         EMIT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = k_ff[AW-1:0];
            state_in = EMIT_LD;
         end
         EMIT_LD: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.out_byte  = cfg.invert ? ~rd_data : rd_data;
               rsp_data_in.last_byte = k_last;
               if (k_last) begin
                  clear    = 1'b1;
                  pen_in   = 16'd0;
                  span_in  = 8'd0;
                  carry_in = 8'd0;
                  state_in = IDLE;
               end else begin
                  k_in     = k_ff + CW'(1);
                  state_in = EMIT_RD;
               end
            end
         end
         CLEAR_ROW: begin
            clear    = 1'b1;
            pen_in   = 16'd0;
            span_in  = 8'd0;
            carry_in = 8'd0;
            state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= IDLE;
         pen_ff       <= 16'd0;
         span_ff      <= 8'd0;
         carry_ff     <= 8'd0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_ff       <= pen_in;
         span_ff      <= span_in;
         carry_ff     <= carry_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ hw/rtl/mono_glyph_row_compositor_top.sv @@
// Top level of the mono glyph row compositor: configuration registers,
// sequencer and line buffer memory.
// Depends on mgrc_pkg, mgrc_ctrl and mgrc_line_mem.
//
//   channel   direction  handshake            payload
//   req_*     in         req_valid/req_stall  req_type  (glyph byte or end of row)
//   rsp_*     out        rsp_valid/rsp_stall  rsp_type  (one scan line byte)
//   csr_*     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A glyph byte is a read, then a write back; the last byte of a span
// adds one more read-modify-write for the trailing carry. End of row
// reads each byte and then loads it into the output register, one byte
// after another, as the line memory has a single, registered read port.
// Reset is synchronous; per-entry valid bits clear the buffer at once,
// so there is no clearing pass. A stalled result holds in the output
// register; the sequencer waits for it with req_stall high, so no item
// enters until the last byte of the row is in the output register.
module mono_glyph_row_compositor_top
   import mgrc_pkg::*;
#(
   parameter int MAX_ROW_BYTES = MGRC_MAX_ROW_BYTES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   localparam int AW = $clog2(MAX_ROW_BYTES);

   logic signed [7:0] char_space_ff;
   logic              invert_ff;
   logic [6:0]        row_bytes_ff;
   cfg_type           cfg;

   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          clear;
   logic [7:0]    rd_data;

   // Configuration writes are always taken; unknown indexes drop.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         char_space_ff <= 8'sd0;
         invert_ff     <= 1'b0;
         row_bytes_ff  <= ROW_BYTES_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHAR_SPACE: char_space_ff <= signed'(csr_wdata);
            CSR_INVERT:     invert_ff     <= csr_wdata[0];
            CSR_ROW_BYTES:  row_bytes_ff  <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign cfg.char_space = char_space_ff;
   assign cfg.invert     = invert_ff;
   assign cfg.row_bytes  = row_bytes_ff;

   mgrc_ctrl #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .clear    (clear),
      .rd_data  (rd_data)
   );

   mgrc_line_mem #(
      .MAX_ROW_BYTES(MAX_ROW_BYTES)
   ) u_line_mem (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .clear  (clear),
      .rd_data(rd_data)
   );

endmodule

@@ hw/rtl/mgrc_checker.sv @@
// Port-level checks for the compositor, bound to the top level.
// Depends on mgrc_pkg and mono_glyph_row_compositor_top.
module mgrc_checker
   import mgrc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input rsp_type                rsp_data
);

   // Hold a stalled item.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // Drop any result on reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Every accepted item leaves the block busy, so no input is taken back to back.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken on back-to-back cycles");

   // Come out of reset ready for an input item.
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind mono_glyph_row_compositor_top mgrc_checker u_mgrc_checker (.*);
